// ===== design/lpsr_pkg.sv =====
package lpsr_pkg;

   localparam int OP_W = 2;
   localparam int LED_W = 6;
   localparam int BRIGHT_W = 8;
   localparam int RED_W = 8;
   localparam int REACH = 14;
   localparam int DIST_W = 4;
   localparam int WEIGHT_W = 9;
   localparam int WEIGHT_FRAC = 8;
   localparam int CONTRIB_W = BRIGHT_W + WEIGHT_W - WEIGHT_FRAC;
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = 1;
   localparam int CMD_CNT_W = 2;
   localparam logic [RED_W-1:0] RED_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_SPAWN  = 2'd0,
      OP_TICK   = 2'd1,
      OP_RENDER = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_SPAWN,
      KIND_TICK,
      KIND_RENDER
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic                  direction;
      logic [BRIGHT_W-1:0]   brightness;
      logic [LED_W-1:0]      led_index;
      logic [RED_W-1:0]      base_red;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } back_state_type;

   function automatic logic [WEIGHT_W-1:0] weight_lookup(input logic [DIST_W-1:0] delta);
      logic [WEIGHT_W-1:0] w;
      unique case (delta)
         4'd0: w = 9'd256;
         4'd1: w = 9'd245;
         4'd2: w = 9'd216;
         4'd3: w = 9'd175;
         4'd4: w = 9'd131;
         4'd5: w = 9'd90;
         4'd6: w = 9'd57;
         4'd7: w = 9'd33;
         4'd8: w = 9'd17;
         4'd9: w = 9'd8;
         4'd10: w = 9'd3;
         4'd11: w = 9'd1;
         default: w = 9'd0;
      endcase
      return w;
   endfunction

endpackage

// ===== design/lpsr_front.sv =====
module lpsr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [lpsr_pkg::OP_W-1:0]     req_op,
   input  logic                          req_direction,
   input  logic [lpsr_pkg::BRIGHT_W-1:0] req_brightness,
   input  logic [lpsr_pkg::LED_W-1:0]    req_led_index,
   input  logic [lpsr_pkg::RED_W-1:0]    req_base_red,
   output logic                          cmd_valid,
   input  logic                          cmd_take,
   output lpsr_pkg::cmd_type             cmd
);
   import lpsr_pkg::*;

   cmd_type               queue_ff [CMD_DEPTH];
   cmd_type               queue_in [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]  count_ff, count_in;
   cmd_type               new_cmd;
   logic                  store;
   op_type                op;

   assign op = op_type'(req_op);
   assign full = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd = queue_ff[rd_ptr_ff];

   // Unused op codes are accepted and discarded here.
   always_comb begin
      new_cmd.direction = req_direction;
      new_cmd.brightness = req_brightness;
      new_cmd.led_index = req_led_index;
      new_cmd.base_red = req_base_red;
      new_cmd.kind = KIND_SPAWN;
      store = 1'b0;
      unique case (op)
         OP_SPAWN: begin
            new_cmd.kind = KIND_SPAWN;
            store = push && !full;
         end
         OP_TICK: begin
            new_cmd.kind = KIND_TICK;
            store = push && !full;
         end
         OP_RENDER: begin
            new_cmd.kind = KIND_RENDER;
            store = push && !full;
         end
         OP_NONE: begin
            store = 1'b0;
         end
      endcase
   end

   always_comb begin
      queue_in = queue_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (store) begin
         queue_in[wr_ptr_ff] = new_cmd;
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (cmd_take) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      unique case ({store, cmd_take})
         2'b10: count_in = count_ff + 1'b1;
         2'b01: count_in = count_ff - 1'b1;
         2'b00: count_in = count_ff;
         2'b11: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CMD_CNT_W'(CMD_DEPTH))
      else $error("command queue count out of range");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (store && !cmd_take) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("command queue lost a stored transaction");

endmodule

// ===== design/lpsr_back.sv =====
module lpsr_back #(
   parameter int STRIP_LEDS = 64,
   parameter int PULSE_SLOTS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   output logic                        cmd_take,
   input  lpsr_pkg::cmd_type           cmd,
   output logic                        empty,
   input  logic                        pop,
   output logic [lpsr_pkg::RED_W-1:0]  rsp_red_out,
   output logic [lpsr_pkg::LED_W-1:0]  rsp_led_number
);
   import lpsr_pkg::*;

   localparam int POS_W = $clog2(2 * STRIP_LEDS);
   localparam int CALC_W = POS_W + 2;
   localparam int SLOT_W = (PULSE_SLOTS > 1) ? $clog2(PULSE_SLOTS) : 1;
   localparam int PROD_W = BRIGHT_W + WEIGHT_W;
   localparam int SUM_W = RED_W + 2;
   localparam logic [POS_W-1:0] POS_RIGHT = POS_W'(2 * (STRIP_LEDS - 1));
   localparam logic [POS_W:0] POS_HIGH = (POS_W + 1)'(STRIP_LEDS + REACH);
   localparam logic [POS_W:0] POS_LOW = (POS_W + 1)'(STRIP_LEDS - REACH);
   localparam logic [CALC_W-1:0] LED_COUNT = CALC_W'(STRIP_LEDS);
   localparam logic [CALC_W-1:0] LED_HALF = CALC_W'(STRIP_LEDS / 2);
   localparam logic [CALC_W-1:0] DIST_LIMIT = CALC_W'(REACH);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PULSE_SLOTS - 1);

   logic [POS_W-1:0]     pos_ff [PULSE_SLOTS];
   logic [POS_W-1:0]     pos_in [PULSE_SLOTS];
   logic [BRIGHT_W-1:0]  bright_ff [PULSE_SLOTS];
   logic [BRIGHT_W-1:0]  bright_in [PULSE_SLOTS];
   logic [PULSE_SLOTS-1:0] dir_ff, dir_in;
   logic [PULSE_SLOTS-1:0] active_ff, active_in;

   back_state_type       state_ff, state_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic [LED_W-1:0]     led_ff, led_in;
   logic [RED_W-1:0]     acc_ff, acc_in;
   logic [CONTRIB_W-1:0] contrib_ff, contrib_in;
   logic                 contrib_valid_ff, contrib_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RED_W-1:0]     rsp_red_ff, rsp_red_in;
   logic [LED_W-1:0]     rsp_led_ff, rsp_led_in;
   logic                 rsp_load;

   logic                 free_found, same_found, spawn_hit;
   logic [SLOT_W-1:0]    free_idx, same_idx, spawn_idx;
   logic [POS_W:0]       step_up [PULSE_SLOTS];
   logic [POS_W:0]       step_down [PULSE_SLOTS];

   logic [CALC_W-1:0]    twice_led, pos_ext, led_ext, delta;
   logic                 slot_counts;
   logic [PROD_W-1:0]    product;
   logic [CONTRIB_W-1:0] slot_contrib;
   logic [SUM_W-1:0]     acc_sum;
   logic [RED_W-1:0]     acc_sat;

   assign empty = !rsp_valid_ff;
   assign rsp_red_out = rsp_red_ff;
   assign rsp_led_number = rsp_led_ff;

   // Lowest free slot first, otherwise the lowest slot heading the same way.
   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      same_found = 1'b0;
      same_idx = '0;
      for (int k = PULSE_SLOTS - 1; k >= 0; k--) begin
         if (!active_ff[k]) begin
            free_found = 1'b1;
            free_idx = SLOT_W'(k);
         end
         if (dir_ff[k] == cmd.direction) begin
            same_found = 1'b1;
            same_idx = SLOT_W'(k);
         end
      end
      spawn_hit = free_found || same_found;
      spawn_idx = free_found ? free_idx : same_idx;
   end

   always_comb begin
      for (int k = 0; k < PULSE_SLOTS; k++) begin
         step_up[k] = {1'b0, pos_ff[k]} + 1'b1;
         step_down[k] = {1'b0, pos_ff[k]} - 1'b1;
      end
   end

   always_comb begin
      twice_led = CALC_W'({led_ff, 1'b0});
      led_ext = CALC_W'(led_ff);
      pos_ext = CALC_W'(pos_ff[idx_ff]);
      delta = (twice_led >= pos_ext) ? (twice_led - pos_ext) : (pos_ext - twice_led);
      slot_counts = (led_ext < LED_COUNT) && active_ff[idx_ff]
         && ((dir_ff[idx_ff] == 1'b0) == (led_ext < LED_HALF)) && (delta < DIST_LIMIT);
      product = PROD_W'(bright_ff[idx_ff]) * PROD_W'(weight_lookup(delta[DIST_W-1:0]));
      slot_contrib = slot_counts ? product[PROD_W-1:WEIGHT_FRAC] : '0;
      acc_sum = SUM_W'(acc_ff) + SUM_W'(contrib_ff);
      acc_sat = (acc_sum > SUM_W'(RED_MAX)) ? RED_MAX : acc_sum[RED_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      bright_in = bright_ff;
      dir_in = dir_ff;
      active_in = active_ff;
      idx_in = idx_ff;
      led_in = led_ff;
      acc_in = contrib_valid_ff ? acc_sat : acc_ff;
      contrib_in = contrib_ff;
      contrib_valid_in = 1'b0;
      cmd_take = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               unique case (cmd.kind)
                  KIND_SPAWN: begin
                     if (spawn_hit) begin
                        pos_in[spawn_idx] = cmd.direction ? POS_RIGHT : '0;
                        dir_in[spawn_idx] = cmd.direction;
                        bright_in[spawn_idx] = cmd.brightness;
                        active_in[spawn_idx] = 1'b1;
                     end
                  end
                  KIND_TICK: begin
                     for (int k = 0; k < PULSE_SLOTS; k++) begin
                        if (active_ff[k]) begin
                           if (!dir_ff[k]) begin
                              pos_in[k] = step_up[k][POS_W-1:0];
                              active_in[k] = !(step_up[k] > POS_HIGH);
                           end else begin
                              pos_in[k] = step_down[k][POS_W-1:0];
                              active_in[k] = !(step_down[k] < POS_LOW);
                           end
                        end
                     end
                  end
                  KIND_RENDER: begin
                     led_in = cmd.led_index;
                     acc_in = cmd.base_red;
                     idx_in = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            contrib_in = slot_contrib;
            contrib_valid_in = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == SLOT_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || pop) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      rsp_red_in = rsp_red_ff;
      rsp_led_in = rsp_led_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      if (rsp_load) begin
         rsp_red_in = acc_ff;
         rsp_led_in = led_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      bright_ff <= bright_in;
      dir_ff <= dir_in;
      idx_ff <= idx_in;
      led_ff <= led_in;
      acc_ff <= acc_in;
      contrib_ff <= contrib_in;
      rsp_red_ff <= rsp_red_in;
      rsp_led_ff <= rsp_led_in;
      if (reset) begin
         for (int k = 0; k < PULSE_SLOTS; k++) begin
            pos_ff[k] <= '0;
            bright_ff[k] <= '0;
         end
         dir_ff <= '0;
         active_ff <= '0;
         state_ff <= ST_IDLE;
         contrib_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         state_ff <= state_in;
         contrib_valid_ff <= contrib_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> (state_ff == ST_IDLE && cmd_valid))
      else $error("command taken outside the idle state");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || pop))
      else $error("result register overwritten before it was popped");

   a_spawn_active: assert property (@(posedge clock) disable iff (reset)
      (cmd_take && cmd.kind == KIND_SPAWN) |=> (active_ff != '0))
      else $error("spawn left no active slot");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && idx_ff == SLOT_LAST) |=> (state_ff == ST_DRAIN))
      else $error("render scan did not end after the last slot");

endmodule

// ===== design/led_pulse_slot_renderer.sv =====
// A render transaction passes the command queue, then the engine's idle, scan, drain and
// done states before its result is loaded into the rsp register; the engine takes no new
// command until then. The scan weighs one slot per cycle; idle handles a spawn or tick.
// A two-entry command queue keeps accepting while the engine works or a result waits.
// Reset is synchronous and active high; it empties both queues and clears every slot.
module led_pulse_slot_renderer #(
   parameter int STRIP_LEDS = 64,
   parameter int PULSE_SLOTS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [lpsr_pkg::OP_W-1:0]     req_op,
   input  logic                          req_direction,
   input  logic [lpsr_pkg::BRIGHT_W-1:0] req_brightness,
   input  logic [lpsr_pkg::LED_W-1:0]    req_led_index,
   input  logic [lpsr_pkg::RED_W-1:0]    req_base_red,
   output logic                          empty,
   input  logic                          pop,
   output logic [lpsr_pkg::RED_W-1:0]    rsp_red_out,
   output logic [lpsr_pkg::LED_W-1:0]    rsp_led_number
);
   import lpsr_pkg::*;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   lpsr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_op         (req_op),
      .req_direction  (req_direction),
      .req_brightness (req_brightness),
      .req_led_index  (req_led_index),
      .req_base_red   (req_base_red),
      .cmd_valid      (cmd_valid),
      .cmd_take       (cmd_take),
      .cmd            (cmd)
   );

   lpsr_back #(
      .STRIP_LEDS  (STRIP_LEDS),
      .PULSE_SLOTS (PULSE_SLOTS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_take       (cmd_take),
      .cmd            (cmd),
      .empty          (empty),
      .pop            (pop),
      .rsp_red_out    (rsp_red_out),
      .rsp_led_number (rsp_led_number)
   );

endmodule

// ===== verif/tb_led_pulse_slot_renderer.sv =====
`timescale 1ns / 1ps

module tb_led_pulse_slot_renderer;
   import lpsr_pkg::*;

   localparam int STRIP_LEDS = 64;
   localparam int PULSE_SLOTS = 4;
   localparam int RANDOM_ITEMS = 1050;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = PULSE_SLOTS + 12;
   localparam int LEFT_START = 0;
   localparam int RIGHT_START = 2 * (STRIP_LEDS - 1);
   localparam int unsigned SEND_GAP [4] = '{0, 49, 0, 37};
   localparam int unsigned RECV_STALL [4] = '{0, 0, 49, 37};

   typedef struct {
      op_type              op;
      logic                direction;
      logic [BRIGHT_W-1:0] brightness;
      logic [LED_W-1:0]    led_index;
      logic [RED_W-1:0]    base_red;
      bit                  fixed;
      logic [RED_W-1:0]    fixed_red;
   } stim_row_type;

   typedef struct {
      logic [RED_W-1:0] red;
      logic [LED_W-1:0] led;
   } pixel_type;

   logic                clock;
   logic                reset;
   logic                push;
   logic                full;
   logic [OP_W-1:0]     req_op;
   logic                req_direction;
   logic [BRIGHT_W-1:0] req_brightness;
   logic [LED_W-1:0]    req_led_index;
   logic [RED_W-1:0]    req_base_red;
   logic                empty;
   logic                pop;
   logic [RED_W-1:0]    rsp_red_out;
   logic [LED_W-1:0]    rsp_led_number;

   bit                  req_fixed;
   logic [RED_W-1:0]    req_fixed_red;
   int unsigned         gap_pct;
   int unsigned         stall_pct;
   int                  mismatches;
   int                  cycle_count;
   pixel_type           expected_pixels[$];

   int unsigned         falloff [0:REACH-1] =
      '{256, 245, 216, 175, 131, 90, 57, 33, 17, 8, 3, 1, 0, 0};
   int                  pulse_pos [PULSE_SLOTS];
   bit                  pulse_dir [PULSE_SLOTS];
   logic [BRIGHT_W-1:0] pulse_level [PULSE_SLOTS];
   bit                  pulse_live [PULSE_SLOTS];

   led_pulse_slot_renderer #(
      .STRIP_LEDS(STRIP_LEDS),
      .PULSE_SLOTS(PULSE_SLOTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_op(req_op),
      .req_direction(req_direction),
      .req_brightness(req_brightness),
      .req_led_index(req_led_index),
      .req_base_red(req_base_red),
      .empty(empty),
      .pop(pop),
      .rsp_red_out(rsp_red_out),
      .rsp_led_number(rsp_led_number)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   // Updates the pulse slots for one accepted transaction and returns 1 when it yields a pixel.
   function automatic bit predict_pixel(input logic [OP_W-1:0] op, input logic dir,
                                        input logic [BRIGHT_W-1:0] level,
                                        input logic [LED_W-1:0] led,
                                        input logic [RED_W-1:0] base,
                                        output pixel_type px);
      int slot;
      int delta;
      int sum;
      slot = -1;
      px.red = base;
      px.led = led;
      case (op)
         OP_SPAWN: begin
            for (int k = PULSE_SLOTS - 1; k >= 0; k--)
               if (!pulse_live[k]) slot = k;
            if (slot < 0)
               for (int k = PULSE_SLOTS - 1; k >= 0; k--)
                  if (pulse_dir[k] == dir) slot = k;
            if (slot >= 0) begin
               pulse_pos[slot] = dir ? RIGHT_START : LEFT_START;
               pulse_dir[slot] = dir;
               pulse_level[slot] = level;
               pulse_live[slot] = 1'b1;
            end
            return 1'b0;
         end
         OP_TICK: begin
            for (int k = 0; k < PULSE_SLOTS; k++) begin
               if (pulse_live[k]) begin
                  if (!pulse_dir[k]) begin
                     pulse_pos[k]++;
                     if (pulse_pos[k] > STRIP_LEDS + REACH) pulse_live[k] = 1'b0;
                  end else begin
                     pulse_pos[k]--;
                     if (pulse_pos[k] < STRIP_LEDS - REACH) pulse_live[k] = 1'b0;
                  end
               end
            end
            return 1'b0;
         end
         OP_RENDER: begin
            sum = int'(base);
            if (int'(led) < STRIP_LEDS) begin
               for (int k = 0; k < PULSE_SLOTS; k++) begin
                  if (pulse_live[k] && ((pulse_dir[k] == 1'b0) == (int'(led) < STRIP_LEDS / 2)))
                  begin
                     delta = 2 * int'(led) - pulse_pos[k];
                     if (delta < 0) delta = -delta;
                     if (delta < REACH) begin
                        sum += (int'(pulse_level[k]) * int'(falloff[delta])) >> WEIGHT_FRAC;
                        if (sum > 255) sum = 255;
                     end
                  end
               end
            end
            px.red = RED_W'(sum);
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic send_item(input stim_row_type row);
      while ($urandom_range(99) < gap_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_op <= row.op;
      req_direction <= row.direction;
      req_brightness <= row.brightness;
      req_led_index <= row.led_index;
      req_base_red <= row.base_red;
      req_fixed <= row.fixed;
      req_fixed_red <= row.fixed_red;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : monitor
      pixel_type px;
      pixel_type want;
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel red=%0d led=%0d",
                                         rsp_red_out, rsp_led_number));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_red_out !== want.red)
                  report_mismatch($sformatf("led %0d: red_out %0d, expected %0d",
                                            want.led, rsp_red_out, want.red));
               if (rsp_led_number !== want.led)
                  report_mismatch($sformatf("led_number %0d, expected %0d",
                                            rsp_led_number, want.led));
            end
         end
         if (push && !full) begin
            if (predict_pixel(req_op, req_direction, req_brightness, req_led_index,
                              req_base_red, px)) begin
               if (req_fixed) px.red = req_fixed_red;
               expected_pixels.push_back(px);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      stim_row_type directed_rows[$];
      stim_row_type row;
      int counted;
      int phase;
      int pick;
      int near_slot;
      int led_guess;

      reset = 1'b1;
      push = 1'b0;
      req_op = OP_NONE;
      req_direction = 1'b0;
      req_brightness = '0;
      req_led_index = '0;
      req_base_red = '0;
      req_fixed = 1'b0;
      req_fixed_red = '0;
      pop = 1'b0;
      gap_pct = 0;
      stall_pct = 0;
      mismatches = 0;
      cycle_count = 0;
      for (int k = 0; k < PULSE_SLOTS; k++) begin
         pulse_pos[k] = 0;
         pulse_dir[k] = 1'b0;
         pulse_level[k] = '0;
         pulse_live[k] = 1'b0;
      end

      // Fields: op, direction, brightness, led_index, base_red, fixed, fixed_red.
      directed_rows = '{
         '{OP_RENDER, 0,   0,  0,   0, 1,   0},
         '{OP_RENDER, 0,   0, 63, 255, 1, 255},
         '{OP_NONE,   0,   0,  0,   0, 0,   0},
         '{OP_TICK,   0,   0,  0,   0, 0,   0},
         '{OP_SPAWN,  0, 255,  0,   0, 0,   0},
         '{OP_RENDER, 0,   0,  0,   0, 1, 255},
         '{OP_RENDER, 0,   0,  0, 200, 1, 255},
         '{OP_SPAWN,  0,   0,  0,   0, 0,   0},
         '{OP_SPAWN,  0, 128,  0,   0, 0,   0},
         '{OP_SPAWN,  0,  77,  0,   0, 0,   0},
         '{OP_SPAWN,  1, 255,  0,   0, 0,   0},
         '{OP_RENDER, 0,   0, 63,   9, 1,   9},
         '{OP_SPAWN,  0, 100,  0,   0, 0,   0},
         '{OP_RENDER, 0,   0,  0,   0, 0,   0},
         '{OP_TICK,   0,   0,  0,   0, 0,   0},
         '{OP_RENDER, 0,   0,  1,   3, 0,   0},
         '{OP_NONE,   1, 255, 63, 255, 0,   0},
         '{OP_RENDER, 0,   0, 31,   0, 0,   0},
         '{OP_RENDER, 0,   0, 32,   1, 0,   0}
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         phase = counted * 4 / RANDOM_ITEMS;
         gap_pct = SEND_GAP[phase];
         stall_pct = RECV_STALL[phase];
         row.direction = 1'($urandom_range(1));
         row.brightness = BRIGHT_W'($urandom_range(255));
         row.led_index = LED_W'($urandom_range(63));
         row.base_red = RED_W'($urandom_range(255));
         row.fixed = 1'b0;
         row.fixed_red = '0;
         pick = int'($urandom_range(99));
         if (pick < 6) row.op = OP_SPAWN;
         else if (pick < 30) row.op = OP_TICK;
         else if (pick < 96) row.op = OP_RENDER;
         else row.op = OP_NONE;
         if (row.op == OP_RENDER && $urandom_range(1)) begin
            near_slot = int'($urandom_range(PULSE_SLOTS - 1));
            if (pulse_live[near_slot]) begin
               led_guess = pulse_pos[near_slot] / 2 + int'($urandom_range(14)) - 7;
               if (led_guess < 0) led_guess = 0;
               if (led_guess > STRIP_LEDS - 1) led_guess = STRIP_LEDS - 1;
               row.led_index = LED_W'(led_guess);
            end
         end
         if (row.op != OP_NONE) counted++;
         send_item(row);
      end

      push <= 1'b0;
      stall_pct = 0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
